>>> design/psmc_pkg.sv
// Shared constants, types and arithmetic helpers for the mouse packet cursor block.
`timescale 1ns / 1ps

package psmc_pkg;

   // cursor position storage and port widths
   localparam int POS_BITS    = 12;
   localparam int CURSOR_BITS = 12;
   localparam int LIMIT_BITS  = 13;
   localparam int BYTE_BITS   = 8;
   localparam int DELTA_BITS  = BYTE_BITS + 1;
   localparam int BTN_BITS    = 3;

   // wide enough for pos + delta with sign, and for a full limit value with sign
   localparam int CMP_BITS = ((LIMIT_BITS > POS_BITS + 1) ? LIMIT_BITS : POS_BITS + 1) + 1;

   localparam logic [CMP_BITS-1:0] POS_TOP = CMP_BITS'(1) << POS_BITS;

   // reset values
   localparam logic [POS_BITS-1:0]   POS_X_RESET        = POS_BITS'(512);
   localparam logic [POS_BITS-1:0]   POS_Y_RESET        = POS_BITS'(384);
   localparam logic [LIMIT_BITS-1:0] WIDTH_LIMIT_RESET  = LIMIT_BITS'(1024);
   localparam logic [LIMIT_BITS-1:0] HEIGHT_LIMIT_RESET = LIMIT_BITS'(768);

   // header byte layout
   localparam int HDR_SYNC_BIT   = 3;
   localparam int HDR_XSIGN_BIT  = 4;
   localparam int HDR_YSIGN_BIT  = 5;
   localparam int HDR_XOVF_BIT   = 6;
   localparam int HDR_YOVF_BIT   = 7;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDTH_LIMIT  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEIGHT_LIMIT = 1'b1;

   // packet queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // decoded packet handed from the front to the back
   typedef struct packed {
      logic                         drop;
      logic [BTN_BITS-1:0]          buttons;
      logic signed [DELTA_BITS-1:0] dx;
      logic signed [DELTA_BITS-1:0] dy;
   } packet_type;

   // queue status seen by both neighbors
   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

   // limit of zero acts as one, anything above the position range acts as its top
   function automatic logic [CMP_BITS-1:0] eff_limit(input logic [LIMIT_BITS-1:0] lim);
      logic [CMP_BITS-1:0] ext;
      ext = CMP_BITS'(lim);
      if (lim == '0) begin
         ext = CMP_BITS'(1);
      end else if (ext > POS_TOP) begin
         ext = POS_TOP;
      end
      return ext;
   endfunction

   function automatic logic [POS_BITS-1:0] clamp_axis(input logic signed [CMP_BITS-1:0] v,
                                                      input logic [CMP_BITS-1:0] lim);
      logic [CMP_BITS-1:0] res;
      if (v[CMP_BITS-1]) begin
         res = '0;
      end else if ($unsigned(v) >= lim) begin
         res = lim - CMP_BITS'(1);
      end else begin
         res = $unsigned(v);
      end
      return res[POS_BITS-1:0];
   endfunction

endpackage

>>> design/psmc_front.sv
// Front end: filters controller reads and assembles three-byte packets.
`timescale 1ns / 1ps

module psmc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_data_ready,
   input  logic                            req_from_aux,
   input  logic [psmc_pkg::BYTE_BITS-1:0]  req_data_byte,
   input  psmc_pkg::queue_status_type      q_status,
   output logic                            push,
   output psmc_pkg::packet_type            push_entry
);

   typedef enum logic [2:0] {
      PH_HEAD  = 3'b001,
      PH_XBYTE = 3'b010,
      PH_YBYTE = 3'b100
   } phase_type;

   phase_type                        phase_ff, phase_in;
   logic [psmc_pkg::BYTE_BITS-1:0]   header_ff, header_in;
   logic [psmc_pkg::BYTE_BITS-1:0]   xbyte_ff, xbyte_in;
   logic                             take;

   assign req_stall = q_status.full;
   assign take = req_valid && !req_stall && req_data_ready && req_from_aux;

   always_comb begin
      phase_in  = phase_ff;
      header_in = header_ff;
      xbyte_in  = xbyte_ff;
      push      = 1'b0;
      if (take) begin
         unique case (phase_ff)
            PH_HEAD: begin
               // drop bytes until one carries the sync bit
               if (req_data_byte[psmc_pkg::HDR_SYNC_BIT]) begin
                  header_in = req_data_byte;
                  phase_in  = PH_XBYTE;
               end
            end
            PH_XBYTE: begin
               xbyte_in = req_data_byte;
               phase_in = PH_YBYTE;
            end
            PH_YBYTE: begin
               push     = 1'b1;
               phase_in = PH_HEAD;
            end
            default: begin
               phase_in = PH_HEAD;
            end
         endcase
      end
   end

   always_comb begin
      push_entry.drop    = header_ff[psmc_pkg::HDR_XOVF_BIT] | header_ff[psmc_pkg::HDR_YOVF_BIT];
      push_entry.buttons = header_ff[psmc_pkg::BTN_BITS-1:0];
      push_entry.dx      = $signed({header_ff[psmc_pkg::HDR_XSIGN_BIT], xbyte_ff});
      push_entry.dy      = $signed({header_ff[psmc_pkg::HDR_YSIGN_BIT], req_data_byte});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEAD;
         header_ff <= '0;
         xbyte_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         xbyte_ff  <= xbyte_in;
      end
   end

endmodule

>>> design/psmc_queue.sv
// Short packet queue between the front end and the cursor back end.
`timescale 1ns / 1ps

module psmc_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  psmc_pkg::packet_type         push_entry,
   input  logic                         pop,
   output psmc_pkg::packet_type         pop_entry,
   output psmc_pkg::queue_status_type   status
);

   psmc_pkg::packet_type                 mem [psmc_pkg::QUEUE_DEPTH];
   logic [psmc_pkg::QPTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [psmc_pkg::QPTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [psmc_pkg::QCNT_BITS-1:0]       count_ff, count_in;

   function automatic logic [psmc_pkg::QPTR_BITS-1:0] next_ptr(
         input logic [psmc_pkg::QPTR_BITS-1:0] p);
      logic [psmc_pkg::QPTR_BITS-1:0] n;
      n = p + psmc_pkg::QPTR_BITS'(1);
      if (p == psmc_pkg::QPTR_BITS'(psmc_pkg::QUEUE_DEPTH - 1)) begin
         n = '0;
      end
      return n;
   endfunction

   assign status.full  = (count_ff == psmc_pkg::QCNT_BITS'(psmc_pkg::QUEUE_DEPTH));
   assign status.valid = (count_ff != '0);
   assign pop_entry    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + psmc_pkg::QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - psmc_pkg::QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (!status.full || pop))
      else $error("packet pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> status.valid)
      else $error("packet popped from an empty queue");

endmodule

>>> design/psmc_back.sv
// Back end: applies packets to the cursor, clamps it and holds the result beat.
`timescale 1ns / 1ps

module psmc_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [psmc_pkg::LIMIT_BITS-1:0]     width_limit,
   input  logic [psmc_pkg::LIMIT_BITS-1:0]     height_limit,
   input  psmc_pkg::queue_status_type          q_status,
   input  psmc_pkg::packet_type                pop_entry,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [psmc_pkg::CURSOR_BITS-1:0]    rsp_cursor_x,
   output logic [psmc_pkg::CURSOR_BITS-1:0]    rsp_cursor_y,
   output logic [psmc_pkg::BTN_BITS-1:0]       rsp_button_bits,
   output logic                                rsp_overflow_dropped
);

   logic [psmc_pkg::POS_BITS-1:0]          pos_x_ff, pos_x_in;
   logic [psmc_pkg::POS_BITS-1:0]          pos_y_ff, pos_y_in;
   logic [psmc_pkg::BTN_BITS-1:0]          btn_ff, btn_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [psmc_pkg::CURSOR_BITS-1:0]       rsp_x_ff, rsp_y_ff;
   logic [psmc_pkg::BTN_BITS-1:0]          rsp_btn_ff;
   logic                                   rsp_drop_ff;
   logic signed [psmc_pkg::CMP_BITS-1:0]   sum_x, sum_y;

   // take a packet whenever the output register is free or being emptied
   assign pop = q_status.valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      sum_x = $signed({{(psmc_pkg::CMP_BITS - psmc_pkg::POS_BITS){1'b0}}, pos_x_ff})
            + $signed({{(psmc_pkg::CMP_BITS - psmc_pkg::DELTA_BITS){pop_entry.dx[
                 psmc_pkg::DELTA_BITS-1]}}, pop_entry.dx});
      // screen y grows downward, so subtract the mouse delta
      sum_y = $signed({{(psmc_pkg::CMP_BITS - psmc_pkg::POS_BITS){1'b0}}, pos_y_ff})
            - $signed({{(psmc_pkg::CMP_BITS - psmc_pkg::DELTA_BITS){pop_entry.dy[
                 psmc_pkg::DELTA_BITS-1]}}, pop_entry.dy});
   end

   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      btn_in   = btn_ff;
      if (pop && !pop_entry.drop) begin
         pos_x_in = psmc_pkg::clamp_axis(sum_x, psmc_pkg::eff_limit(width_limit));
         pos_y_in = psmc_pkg::clamp_axis(sum_y, psmc_pkg::eff_limit(height_limit));
         btn_in   = pop_entry.buttons;
      end
      rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= psmc_pkg::POS_X_RESET;
         pos_y_ff     <= psmc_pkg::POS_Y_RESET;
         btn_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         btn_ff       <= btn_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_x_ff    <= psmc_pkg::CURSOR_BITS'(pos_x_in);
         rsp_y_ff    <= psmc_pkg::CURSOR_BITS'(pos_y_in);
         rsp_btn_ff  <= btn_in;
         rsp_drop_ff <= pop_entry.drop;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_cursor_x         = rsp_x_ff;
   assign rsp_cursor_y         = rsp_y_ff;
   assign rsp_button_bits      = rsp_btn_ff;
   assign rsp_overflow_dropped = rsp_drop_ff;

   a_pop_gives_beat: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("popped packet produced no result beat");

   a_drop_keeps_cursor: assert property (@(posedge clock) disable iff (reset)
      (pop && pop_entry.drop) |=> (pos_x_ff == $past(pos_x_ff)) &&
                                  (pos_y_ff == $past(pos_y_ff)) &&
                                  (btn_ff == $past(btn_ff)))
      else $error("dropped packet changed the cursor state");

endmodule

>>> design/ps2_mouse_packet_cursor.sv
// Top level of the mouse packet cursor: configuration registers and the front/queue/back path.
`timescale 1ns / 1ps

// Takes one controller read per beat and uses it only when both data_ready and
// from_aux are set. Bytes build three-byte mouse packets (a first byte needs its
// sync bit 3); each third byte yields one result beat carrying the clamped cursor
// and buttons, or the unchanged state with overflow_dropped set when the header has
// an overflow bit. A read is accepted every cycle while req_stall is low; a result
// beat is written into the packet queue and then into the output register. The
// two-entry packet queue and the output register set how long the input keeps
// flowing while the result side stalls: the input stalls once two packets wait
// behind a held result. Write width_limit (index 0) and height_limit (index 1)
// only while no packet is in flight.
module ps2_mouse_packet_cursor (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_data_ready,
   input  logic                                 req_from_aux,
   input  logic [psmc_pkg::BYTE_BITS-1:0]       req_data_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [psmc_pkg::CURSOR_BITS-1:0]     rsp_cursor_x,
   output logic [psmc_pkg::CURSOR_BITS-1:0]     rsp_cursor_y,
   output logic [psmc_pkg::BTN_BITS-1:0]        rsp_button_bits,
   output logic                                 rsp_overflow_dropped,
   input  logic                                 csr_write_en,
   input  logic [psmc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [psmc_pkg::LIMIT_BITS-1:0]      csr_wdata
);

   logic [psmc_pkg::LIMIT_BITS-1:0]  width_limit_ff, width_limit_in;
   logic [psmc_pkg::LIMIT_BITS-1:0]  height_limit_ff, height_limit_in;
   psmc_pkg::queue_status_type       q_status;
   psmc_pkg::packet_type             push_entry, pop_entry;
   logic                             push, pop;

   always_comb begin
      width_limit_in  = width_limit_ff;
      height_limit_in = height_limit_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            psmc_pkg::CSR_WIDTH_LIMIT:  width_limit_in  = csr_wdata;
            psmc_pkg::CSR_HEIGHT_LIMIT: height_limit_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_limit_ff  <= psmc_pkg::WIDTH_LIMIT_RESET;
         height_limit_ff <= psmc_pkg::HEIGHT_LIMIT_RESET;
      end else begin
         width_limit_ff  <= width_limit_in;
         height_limit_ff <= height_limit_in;
      end
   end

   psmc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_ready (req_data_ready),
      .req_from_aux   (req_from_aux),
      .req_data_byte  (req_data_byte),
      .q_status       (q_status),
      .push           (push),
      .push_entry     (push_entry)
   );

   psmc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   psmc_back u_back (
      .clock                (clock),
      .reset                (reset),
      .width_limit          (width_limit_ff),
      .height_limit         (height_limit_ff),
      .q_status             (q_status),
      .pop_entry            (pop_entry),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_cursor_x         (rsp_cursor_x),
      .rsp_cursor_y         (rsp_cursor_y),
      .rsp_button_bits      (rsp_button_bits),
      .rsp_overflow_dropped (rsp_overflow_dropped)
   );

endmodule

>>> tb/ps2_mouse_packet_cursor_test.sv
// Self-checking testbench for the mouse packet cursor: packet framing, motion, drops, limits.
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor_test;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int ROUND_ITEMS    = 200;
   localparam int PRINT_LIMIT    = 40;

   localparam logic [1:0] PHASE_HEADER = 2'd0;
   localparam logic [1:0] PHASE_XBYTE  = 2'd1;
   localparam logic [1:0] PHASE_YBYTE  = 2'd2;

   typedef struct packed {
      logic [psmc_pkg::CURSOR_BITS-1:0] x;
      logic [psmc_pkg::CURSOR_BITS-1:0] y;
      logic [psmc_pkg::BTN_BITS-1:0]    buttons;
      logic                             drop;
   } cursor_report_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic                                req_data_ready;
   logic                                req_from_aux;
   logic [psmc_pkg::BYTE_BITS-1:0]      req_data_byte;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [psmc_pkg::CURSOR_BITS-1:0]    rsp_cursor_x;
   logic [psmc_pkg::CURSOR_BITS-1:0]    rsp_cursor_y;
   logic [psmc_pkg::BTN_BITS-1:0]       rsp_button_bits;
   logic                                rsp_overflow_dropped;
   logic                                csr_write_en;
   logic [psmc_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [psmc_pkg::LIMIT_BITS-1:0]     csr_wdata;

   // shadow of the block's state and registers
   logic [1:0]                      pkt_phase   = PHASE_HEADER;
   logic [psmc_pkg::BYTE_BITS-1:0]  pkt_header  = '0;
   logic [psmc_pkg::BYTE_BITS-1:0]  pkt_xbyte   = '0;
   logic [psmc_pkg::POS_BITS-1:0]   cur_x       = psmc_pkg::POS_X_RESET;
   logic [psmc_pkg::POS_BITS-1:0]   cur_y       = psmc_pkg::POS_Y_RESET;
   logic [psmc_pkg::BTN_BITS-1:0]   cur_buttons = '0;
   logic [psmc_pkg::LIMIT_BITS-1:0] scr_width   = psmc_pkg::WIDTH_LIMIT_RESET;
   logic [psmc_pkg::LIMIT_BITS-1:0] scr_height  = psmc_pkg::HEIGHT_LIMIT_RESET;

   cursor_report_type expected_reports[$];
   int mismatch_count = 0;
   int idle_cycles    = 0;
   int max_gap        = 11;
   int stall_left     = 0;

   ps2_mouse_packet_cursor dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_ready       (req_data_ready),
      .req_from_aux         (req_from_aux),
      .req_data_byte        (req_data_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_cursor_x         (rsp_cursor_x),
      .rsp_cursor_y         (rsp_cursor_y),
      .rsp_button_bits      (rsp_button_bits),
      .rsp_overflow_dropped (rsp_overflow_dropped),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [psmc_pkg::POS_BITS-1:0] clamp_to_screen(
         int v, logic [psmc_pkg::LIMIT_BITS-1:0] lim);
      int span;
      span = (lim == '0) ? 1 :
             ((int'(lim) > (1 << psmc_pkg::POS_BITS)) ? (1 << psmc_pkg::POS_BITS) : int'(lim));
      if (v < 0) begin
         v = 0;
      end else if (v >= span) begin
         v = span - 1;
      end
      return v[psmc_pkg::POS_BITS-1:0];
   endfunction

   function automatic void decode_mouse_read(logic rdy, logic aux,
                                             logic [psmc_pkg::BYTE_BITS-1:0] b);
      int dx;
      int dy;
      cursor_report_type rep;
      if (!(rdy && aux)) return;
      if (pkt_phase == PHASE_XBYTE) begin
         pkt_xbyte = b;
         pkt_phase = PHASE_YBYTE;
         return;
      end
      if (pkt_phase != PHASE_YBYTE) begin
         // a header must carry the sync bit, anything else is dropped on the floor
         if (b[psmc_pkg::HDR_SYNC_BIT]) begin
            pkt_header = b;
            pkt_phase  = PHASE_XBYTE;
         end else begin
            pkt_phase = PHASE_HEADER;
         end
         return;
      end
      pkt_phase = PHASE_HEADER;
      rep.drop = pkt_header[psmc_pkg::HDR_XOVF_BIT] | pkt_header[psmc_pkg::HDR_YOVF_BIT];
      if (!rep.drop) begin
         dx = int'(pkt_xbyte) - (pkt_header[psmc_pkg::HDR_XSIGN_BIT] ? 256 : 0);
         dy = int'(b) - (pkt_header[psmc_pkg::HDR_YSIGN_BIT] ? 256 : 0);
         cur_buttons = pkt_header[psmc_pkg::BTN_BITS-1:0];
         cur_x = clamp_to_screen(int'(cur_x) + dx, scr_width);
         // screen y grows downward, mouse y grows upward
         cur_y = clamp_to_screen(int'(cur_y) - dy, scr_height);
      end
      rep.x       = cur_x;
      rep.y       = cur_y;
      rep.buttons = cur_buttons;
      expected_reports.push_back(rep);
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) $display("mismatch at %0t ns: %s", $time, what);
   endtask

   task automatic send_read(input logic rdy, input logic aux,
                            input logic [psmc_pkg::BYTE_BITS-1:0] b);
      int gap;
      gap = (max_gap == 0) ? 0 : $urandom_range(max_gap, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_ready <= rdy;
      req_from_aux   <= aux;
      req_data_byte  <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_mouse_read(rdy, aux, b);
   endtask

   task automatic send_packet(input logic [7:0] hdr, input logic [7:0] xb, input logic [7:0] yb);
      send_read(1'b1, 1'b1, hdr);
      send_read(1'b1, 1'b1, xb);
      send_read(1'b1, 1'b1, yb);
   endtask

   // hold the input and let every outstanding beat leave before touching a register
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [psmc_pkg::CSR_INDEX_BITS-1:0] idx,
                              input logic [psmc_pkg::LIMIT_BITS-1:0] val);
      drain();
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == psmc_pkg::CSR_WIDTH_LIMIT) begin
         scr_width = val;
      end else begin
         scr_height = val;
      end
   endtask

   task automatic set_screen(input logic [psmc_pkg::LIMIT_BITS-1:0] w,
                             input logic [psmc_pkg::LIMIT_BITS-1:0] h);
      write_limit(psmc_pkg::CSR_WIDTH_LIMIT, w);
      write_limit(psmc_pkg::CSR_HEIGHT_LIMIT, h);
   endtask

   task automatic test_reset_and_framing();
      send_read(1'b0, 1'b0, 8'hFF);
      send_read(1'b1, 1'b0, 8'hFF);
      send_read(1'b0, 1'b1, 8'hFF);
      send_read(1'b1, 1'b1, 8'h00);
      send_read(1'b1, 1'b1, 8'hF7);
      send_packet(8'h08, 8'h00, 8'h00);
   endtask

   task automatic test_motion_and_drops();
      send_packet(8'h0F, 8'hFF, 8'h00);
      send_packet(8'h18, 8'h00, 8'h00);
      send_packet(8'h28, 8'h00, 8'h00);
      send_packet(8'h08, 8'h00, 8'hFF);
      // reads without both flags inside a packet must not advance it
      send_read(1'b1, 1'b1, 8'h09);
      send_read(1'b0, 1'b1, 8'h55);
      send_read(1'b1, 1'b1, 8'h10);
      send_read(1'b1, 1'b0, 8'hAA);
      send_read(1'b1, 1'b1, 8'h20);
      send_packet(8'h4B, 8'h40, 8'h40);
      send_packet(8'h88, 8'h01, 8'h01);
      send_packet(8'hFF, 8'hFF, 8'hFF);
   endtask

   task automatic test_limit_corners();
      // cursor sits beyond the new width until the next good packet
      set_screen(13'd100, 13'd8191);
      send_packet(8'h48, 8'h01, 8'h01);
      send_packet(8'h08, 8'h00, 8'h00);
      set_screen(13'd0, 13'd0);
      send_packet(8'h08, 8'h7F, 8'h7F);
      set_screen(13'd8191, 13'd4097);
      send_packet(8'h28, 8'hFF, 8'h00);
      set_screen(13'd4096, 13'd1);
      send_packet(8'h2F, 8'hFF, 8'h00);
   endtask

   task automatic send_random_packet();
      logic [7:0] pkt [3];
      pkt[0] = 8'($urandom_range(255, 0)) | 8'h08;
      // overflow is rare on a real link
      if ($urandom_range(7, 0) != 0) pkt[0] &= 8'h3F;
      pkt[1] = 8'($urandom_range(255, 0));
      pkt[2] = 8'($urandom_range(255, 0));
      for (int i = 0; i < 3; i++) begin
         if ($urandom_range(15, 0) == 0) begin
            send_read(1'b0, 1'($urandom_range(1, 0)), 8'($urandom_range(255, 0)));
         end
         send_read(1'b1, 1'b1, pkt[i]);
      end
   endtask

   task automatic test_random_traffic();
      int used;
      logic rdy;
      logic aux;
      for (int round = 0; round < 7; round++) begin
         case (round)
            0: set_screen(psmc_pkg::WIDTH_LIMIT_RESET, psmc_pkg::HEIGHT_LIMIT_RESET);
            1: set_screen(13'd1, 13'd1);
            2: set_screen(13'd4096, 13'd4096);
            3: set_screen(13'd640, 13'd480);
            4: set_screen(13'($urandom_range(8191, 0)), 13'($urandom_range(8191, 0)));
            5: set_screen(13'd8191, 13'd0);
            default: set_screen(13'($urandom_range(4096, 1)), 13'($urandom_range(4096, 1)));
         endcase
         max_gap = (round == 3) ? 0 : 11;
         used = 0;
         while (used < ROUND_ITEMS) begin
            if ($urandom_range(9, 0) < 8) begin
               send_random_packet();
               used += 3;
            end else if ($urandom_range(1, 0) == 1) begin
               // truncated packet: a lone header that the next bytes continue
               send_read(1'b1, 1'b1, 8'($urandom_range(255, 0)) | 8'h08);
               used++;
            end else begin
               rdy = 1'($urandom_range(1, 0));
               aux = 1'($urandom_range(1, 0));
               send_read(rdy, aux, 8'($urandom_range(255, 0)));
               if (rdy && aux) used++;
            end
         end
      end
      max_gap = 11;
   endtask

   // result side back-pressure: hold stall for a drawn number of valid cycles per beat
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         stall_left = (max_gap == 0) ? 0 : $urandom_range(max_gap, 0);
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         if (rsp_valid) stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_results
      cursor_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            report_mismatch("result beat with no packet pending");
         end else begin
            want = expected_reports.pop_front();
            if (rsp_cursor_x !== want.x)
               report_mismatch($sformatf("cursor_x %0d, want %0d", rsp_cursor_x, want.x));
            if (rsp_cursor_y !== want.y)
               report_mismatch($sformatf("cursor_y %0d, want %0d", rsp_cursor_y, want.y));
            if (rsp_button_bits !== want.buttons)
               report_mismatch($sformatf("button_bits %0h, want %0h",
                                         rsp_button_bits, want.buttons));
            if (rsp_overflow_dropped !== want.drop)
               report_mismatch($sformatf("overflow_dropped %0b, want %0b",
                                         rsp_overflow_dropped, want.drop));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_data_ready <= 1'b0;
      req_from_aux   <= 1'b0;
      req_data_byte  <= '0;
      csr_write_en   <= 1'b0;
      csr_index      <= psmc_pkg::CSR_WIDTH_LIMIT;
      csr_wdata      <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_and_framing();
      test_motion_and_drops();
      test_limit_corners();
      test_random_traffic();

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_reports.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_reports.size()));
      end
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
